// ===== hw/rtl/ray_disc_intersect_2d_assert.svh =====
// assertion macros for the ray/disc intersect rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef RAY_DISC_INTERSECT_2D_ASSERT_SVH
`define RAY_DISC_INTERSECT_2D_ASSERT_SVH

// same-cycle implication
`define RDI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rdi assertion failed");

// next-cycle implication
`define RDI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rdi assertion failed");

`endif

// ===== hw/rtl/rdi_pkg.sv =====
// shared widths, constants and pipeline control type for the ray/disc intersect
// no dependencies
package rdi_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned DirW     = 16;
  localparam int unsigned DistW    = 31;
  localparam int unsigned DirFracW = 14;
  localparam int unsigned NormQuoW = DirFracW + 1;
  localparam int unsigned RndOfs   = 1 << (DirFracW - 1);

  typedef struct packed {
    logic adv;
    logic vld;
  } rdi_ctl_t;

endpackage

// ===== hw/rtl/rdi_if.sv =====
// valid/ready channel interfaces for ray/disc items and results
// depends on rdi_pkg
interface rdi_in_if import rdi_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [CoordW-1:0]   start_x;
  logic signed [CoordW-1:0]   start_y;
  logic signed [DirW-1:0]     dir_x;
  logic signed [DirW-1:0]     dir_y;
  logic        [DistW-1:0]    max_distance;
  logic signed [CoordW-1:0]   center_x;
  logic signed [CoordW-1:0]   center_y;
  logic        [DistW-1:0]    radius;

  modport source (output valid, start_x, start_y, dir_x, dir_y, max_distance,
                  center_x, center_y, radius, input ready);
  modport sink (input valid, start_x, start_y, dir_x, dir_y, max_distance,
                center_x, center_y, radius, output ready);
endinterface

interface rdi_out_if import rdi_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       hit;
  logic        [DistW-1:0]    hit_distance;
  logic signed [CoordW-1:0]   hit_x;
  logic signed [CoordW-1:0]   hit_y;
  logic signed [DirW-1:0]     normal_x;
  logic signed [DirW-1:0]     normal_y;

  modport source (output valid, hit, hit_distance, hit_x, hit_y, normal_x, normal_y,
                  input ready);
  modport sink (input valid, hit, hit_distance, hit_x, hit_y, normal_x, normal_y,
                output ready);
endinterface

// ===== hw/rtl/rdi_sqrt.sv =====
// pipelined integer square root, one root bit per stage, with sideband payload
// depends on rdi_pkg
module rdi_sqrt import rdi_pkg::*; #(
  parameter int unsigned RootW = 31,
  parameter int unsigned PayW  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rdi_ctl_t             ctl_i,
  input  logic [2*RootW-1:0]   rad_i,
  input  logic [PayW-1:0]      pay_i,
  output logic                 vld_o,
  output logic [RootW-1:0]     root_o,
  output logic [PayW-1:0]      pay_o
);

  localparam int unsigned RadW = 2 * RootW;
  localparam int unsigned RemW = RootW + 3;

  logic [RadW-1:0]  rad_q  [RootW];
  logic [RemW-1:0]  rem_q  [RootW];
  logic [RootW-1:0] root_q [RootW];
  logic [PayW-1:0]  pay_q  [RootW];
  logic             vld_q  [RootW];

  for (genvar i = 0; i < RootW; i++) begin : g_step
    logic [RadW-1:0]  rad_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [PayW-1:0]  pay_in;
    logic             vld_in;
    logic [RemW-1:0]  cur;
    logic [RemW-1:0]  trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign pay_in  = pay_i;
      assign vld_in  = ctl_i.vld;
    end else begin : g_next
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign pay_in  = pay_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    assign cur   = {rem_in[RemW-3:0], rad_in[RadW-1 -: 2]};
    assign trial = RemW'({root_in, 2'b01});
    assign ge    = (cur >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        rad_q[i]  <= rad_in << 2;
        rem_q[i]  <= ge ? (cur - trial) : cur;
        root_q[i] <= {root_in[RootW-2:0], ge};
        pay_q[i]  <= pay_in;
      end
    end
  end

  assign vld_o  = vld_q[RootW-1];
  assign root_o = root_q[RootW-1];
  assign pay_o  = pay_q[RootW-1];

endmodule

// ===== hw/rtl/rdi_div.sv =====
// pipelined two-lane restoring divider sharing one divisor, one quotient bit per stage
// depends on rdi_pkg; numerators must stay below den * 2^QuoW
module rdi_div import rdi_pkg::*; #(
  parameter int unsigned QuoW = 15,
  parameter int unsigned DenW = 32,
  parameter int unsigned PayW = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rdi_ctl_t               ctl_i,
  input  logic [QuoW+DenW-1:0]   num_x_i,
  input  logic [QuoW+DenW-1:0]   num_y_i,
  input  logic [DenW-1:0]        den_i,
  input  logic [PayW-1:0]        pay_i,
  output logic                   vld_o,
  output logic [QuoW-1:0]        quo_x_o,
  output logic [QuoW-1:0]        quo_y_o,
  output logic [PayW-1:0]        pay_o
);

  localparam int unsigned NumW = QuoW + DenW;

  logic [NumW-1:0] remx_q [QuoW];
  logic [NumW-1:0] remy_q [QuoW];
  logic [QuoW-1:0] quox_q [QuoW];
  logic [QuoW-1:0] quoy_q [QuoW];
  logic [DenW-1:0] den_q  [QuoW];
  logic [PayW-1:0] pay_q  [QuoW];
  logic            vld_q  [QuoW];

  for (genvar i = 0; i < QuoW; i++) begin : g_step
    logic [NumW-1:0] remx_in;
    logic [NumW-1:0] remy_in;
    logic [QuoW-1:0] quox_in;
    logic [QuoW-1:0] quoy_in;
    logic [DenW-1:0] den_in;
    logic [PayW-1:0] pay_in;
    logic            vld_in;
    logic [NumW-1:0] dsh;
    logic            gex;
    logic            gey;

    if (i == 0) begin : g_first
      assign remx_in = num_x_i;
      assign remy_in = num_y_i;
      assign quox_in = '0;
      assign quoy_in = '0;
      assign den_in  = den_i;
      assign pay_in  = pay_i;
      assign vld_in  = ctl_i.vld;
    end else begin : g_next
      assign remx_in = remx_q[i-1];
      assign remy_in = remy_q[i-1];
      assign quox_in = quox_q[i-1];
      assign quoy_in = quoy_q[i-1];
      assign den_in  = den_q[i-1];
      assign pay_in  = pay_q[i-1];
      assign vld_in  = vld_q[i-1];
    end

    assign dsh = NumW'(den_in) << (QuoW - 1 - i);
    assign gex = (remx_in >= dsh);
    assign gey = (remy_in >= dsh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (ctl_i.adv) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctl_i.adv) begin
        remx_q[i] <= gex ? (remx_in - dsh) : remx_in;
        remy_q[i] <= gey ? (remy_in - dsh) : remy_in;
        quox_q[i] <= {quox_in[QuoW-2:0], gex};
        quoy_q[i] <= {quoy_in[QuoW-2:0], gey};
        den_q[i]  <= den_in;
        pay_q[i]  <= pay_in;
      end
    end
  end

  assign vld_o   = vld_q[QuoW-1];
  assign quo_x_o = quox_q[QuoW-1];
  assign quo_y_o = quoy_q[QuoW-1];
  assign pay_o   = pay_q[QuoW-1];

endmodule

// ===== hw/rtl/ray_disc_intersect_2d.sv =====
// One 2D ray against one disc per beat, fully pipelined: a new beat is taken every cycle
// while the pipe is not held; most of its depth lies in the two square root
// units (31 and 32 stages, one root bit each) and the 15-stage normal divider. The whole
// pipe advances together and holds while the output register is full and not taken, so
// the input is ready whenever the output slot is free or being drained.
// depends on rdi_pkg, rdi_if, rdi_sqrt, rdi_div and the assertion macro header
`include "ray_disc_intersect_2d_assert.svh"

module ray_disc_intersect_2d import rdi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rdi_in_if.sink     in_i,
  rdi_out_if.source  out_o
);

  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned MulW  = DiffW + DirW;
  localparam int unsigned SumW  = MulW + 1;
  localparam int unsigned RndW  = SumW + 1;
  localparam int unsigned P16W  = RndW - DirFracW;
  localparam int unsigned SqW   = 2 * DistW;
  localparam int unsigned H2W   = 2 * CoordW + 1;
  localparam int unsigned DW    = P16W + 1;
  localparam int unsigned HpW   = DistW + 1 + DirW;
  localparam int unsigned HrW   = HpW + 1 - DirFracW;
  localparam int unsigned WW    = HrW + 1;
  localparam int unsigned VW    = WW + 1;
  localparam int unsigned KMax  = VW - CoordW;
  localparam int unsigned AW    = CoordW - 1;
  localparam int unsigned LenW  = CoordW;
  localparam int unsigned NumW  = NormQuoW + LenW;

  typedef struct packed {
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [DirW-1:0]   dx;
    logic signed [DirW-1:0]   dy;
    logic        [DistW-1:0]  maxd;
    logic        [DistW-1:0]  r;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
  } base_t;

  typedef struct packed {
    base_t                  b;
    logic signed [P16W-1:0] p16;
    logic                   miss;
    logic                   ins;
  } pay1_t;

  typedef struct packed {
    logic                     hit;
    logic                     ins;
    logic        [DistW-1:0]  hd;
    logic signed [CoordW-1:0] hx;
    logic signed [CoordW-1:0] hy;
    logic                     sgx;
    logic                     sgy;
    logic signed [DirW-1:0]   nix;
    logic signed [DirW-1:0]   niy;
  } tail_t;

  typedef struct packed {
    tail_t         t;
    logic [AW-1:0] ax;
    logic [AW-1:0] ay;
  } pay2_t;

  typedef struct packed {
    tail_t t;
    logic  lenz;
  } pay3_t;

  localparam int unsigned Pay1W = $bits(pay1_t);
  localparam int unsigned Pay2W = $bits(pay2_t);
  localparam int unsigned Pay3W = $bits(pay3_t);

  logic en;
  logic out_v_q;
  assign en = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, v11_q, v12_q, v13_q;
  logic sq1_vld, sq2_vld, div_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0;
      v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0; v10_q <= 1'b0;
      v11_q <= 1'b0; v12_q <= 1'b0; v13_q <= 1'b0; out_v_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q; v5_q <= v4_q;
      v6_q <= sq1_vld; v7_q <= v6_q; v8_q <= v7_q; v9_q <= v8_q; v10_q <= v9_q;
      v11_q <= v10_q; v12_q <= v11_q; v13_q <= sq2_vld; out_v_q <= div_vld;
    end
  end

  // s1: center minus start
  base_t b1_q;
  logic signed [DiffW-1:0] ddx1_q, ddy1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b1_q.sx   <= in_i.start_x;
      b1_q.sy   <= in_i.start_y;
      b1_q.dx   <= in_i.dir_x;
      b1_q.dy   <= in_i.dir_y;
      b1_q.maxd <= in_i.max_distance;
      b1_q.r    <= in_i.radius;
      b1_q.cx   <= in_i.center_x;
      b1_q.cy   <= in_i.center_y;
      ddx1_q    <= DiffW'(in_i.center_x) - DiffW'(in_i.start_x);
      ddy1_q    <= DiffW'(in_i.center_y) - DiffW'(in_i.start_y);
    end
  end

  // s2: projections products and squares for the inside test
  base_t b2_q;
  logic signed [MulW-1:0] pa2_q, pb2_q, qa2_q, qb2_q;
  logic [SqW-1:0] ax2_2_q, ay2_2_q, r2_2_q;
  logic lt2_q;
  logic [CoordW-1:0] adx1, ady1;

  assign adx1 = ddx1_q[DiffW-1] ? CoordW'(-ddx1_q) : ddx1_q[CoordW-1:0];
  assign ady1 = ddy1_q[DiffW-1] ? CoordW'(-ddy1_q) : ddy1_q[CoordW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      b2_q    <= b1_q;
      pa2_q   <= ddx1_q * b1_q.dx;
      pb2_q   <= ddy1_q * b1_q.dy;
      qa2_q   <= ddy1_q * b1_q.dx;
      qb2_q   <= ddx1_q * b1_q.dy;
      ax2_2_q <= adx1[DistW-1:0] * adx1[DistW-1:0];
      ay2_2_q <= ady1[DistW-1:0] * ady1[DistW-1:0];
      r2_2_q  <= b1_q.r * b1_q.r;
      lt2_q   <= (adx1 < CoordW'(b1_q.r)) && (ady1 < CoordW'(b1_q.r));
    end
  end

  // s3: early rejects, inside test, round projections to q16.16
  base_t b3_q;
  logic signed [P16W-1:0] p16_3_q, q16_3_q;
  logic [SqW-1:0] r2_3_q;
  logic miss3_q, ins3_q;
  logic signed [SumW-1:0] p30, q30, r30, lim30;
  logic signed [RndW-1:0] pr, qr;
  logic [DistW:0] mr;
  logic [SqW:0] a2sum;

  assign p30   = SumW'(pa2_q) + SumW'(pb2_q);
  assign q30   = SumW'(qa2_q) - SumW'(qb2_q);
  assign r30   = $signed(SumW'({b2_q.r, DirFracW'(0)}));
  assign mr    = {1'b0, b2_q.maxd} + {1'b0, b2_q.r};
  assign lim30 = $signed(SumW'({mr, DirFracW'(0)}));
  assign pr    = RndW'(p30) + RndW'(RndOfs);
  assign qr    = RndW'(q30) + RndW'(RndOfs);
  assign a2sum = {1'b0, ax2_2_q} + {1'b0, ay2_2_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      b3_q    <= b2_q;
      p16_3_q <= pr[RndW-1:DirFracW];
      q16_3_q <= qr[RndW-1:DirFracW];
      r2_3_q  <= r2_2_q;
      miss3_q <= (q30 > r30) || (q30 < -r30) || (p30 <= -r30) || (p30 >= lim30);
      ins3_q  <= lt2_q && (a2sum < {1'b0, r2_2_q});
    end
  end

  // s4: perpendicular offset squared
  base_t b4_q;
  logic signed [P16W-1:0] p16_4_q;
  logic [SqW-1:0] r2_4_q;
  logic [2*CoordW-1:0] q2_4_q;
  logic miss4_q, ins4_q;
  logic [CoordW-1:0] aq3;

  assign aq3 = q16_3_q[P16W-1] ? CoordW'(-q16_3_q) : q16_3_q[CoordW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      b4_q    <= b3_q;
      p16_4_q <= p16_3_q;
      r2_4_q  <= r2_3_q;
      q2_4_q  <= aq3 * aq3;
      miss4_q <= miss3_q;
      ins4_q  <= ins3_q;
    end
  end

  // s5: half chord squared, tangent reject
  logic [SqW-1:0] rad5_q;
  pay1_t pay5_q;
  logic signed [H2W-1:0] h2;

  assign h2 = $signed(H2W'(r2_4_q)) - $signed(H2W'(q2_4_q));

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad5_q      <= h2[SqW-1:0];
      pay5_q.b    <= b4_q;
      pay5_q.p16  <= p16_4_q;
      pay5_q.ins  <= ins4_q;
      pay5_q.miss <= miss4_q || (!ins4_q && (h2[H2W-1] || (h2 == '0)));
    end
  end

  logic [DistW-1:0] h_root;
  logic [Pay1W-1:0] pay1_bits;
  pay1_t pay6;

  rdi_sqrt #(
    .RootW (DistW),
    .PayW  (Pay1W)
  ) u_sqrt_chord (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{adv: en, vld: v5_q}),
    .rad_i  (rad5_q),
    .pay_i  (pay5_q),
    .vld_o  (sq1_vld),
    .root_o (h_root),
    .pay_o  (pay1_bits)
  );

  assign pay6 = pay1_bits;

  // s6: hit distance and range check
  base_t b6_q;
  logic [DistW-1:0] d6_q;
  logic hit6_q, ins6_q;
  logic signed [DW-1:0] dfull;
  logic dok;

  assign dfull = DW'(pay6.p16) - $signed(DW'(h_root));
  assign dok   = !dfull[DW-1] && (dfull != '0) && (dfull < $signed(DW'(pay6.b.maxd)));

  always_ff @(posedge clk_i) begin
    if (en) begin
      b6_q   <= pay6.b;
      d6_q   <= pay6.ins ? '0 : dfull[DistW-1:0];
      hit6_q <= !pay6.miss && (pay6.ins || dok);
      ins6_q <= pay6.ins;
    end
  end

  // s7: distance times direction
  base_t b7_q;
  logic [DistW-1:0] d7_q;
  logic hit7_q, ins7_q;
  logic signed [HpW-1:0] prx7_q, pry7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b7_q   <= b6_q;
      d7_q   <= d6_q;
      hit7_q <= hit6_q;
      ins7_q <= ins6_q;
      prx7_q <= $signed({1'b0, d6_q}) * b6_q.dx;
      pry7_q <= $signed({1'b0, d6_q}) * b6_q.dy;
    end
  end

  // s8: wide hit point
  base_t b8_q;
  logic [DistW-1:0] d8_q;
  logic hit8_q, ins8_q;
  logic signed [WW-1:0] wx8_q, wy8_q;
  logic signed [HpW:0] tx7, ty7;
  logic signed [HrW-1:0] rx7, ry7;

  assign tx7 = (HpW+1)'(prx7_q) + (HpW+1)'(RndOfs);
  assign ty7 = (HpW+1)'(pry7_q) + (HpW+1)'(RndOfs);
  assign rx7 = tx7[HpW:DirFracW];
  assign ry7 = ty7[HpW:DirFracW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      b8_q   <= b7_q;
      d8_q   <= d7_q;
      hit8_q <= hit7_q;
      ins8_q <= ins7_q;
      wx8_q  <= WW'(b7_q.sx) + WW'(rx7);
      wy8_q  <= WW'(b7_q.sy) + WW'(ry7);
    end
  end

  // s9: saturate hit point, vector from center
  base_t b9_q;
  logic [DistW-1:0] d9_q;
  logic hit9_q, ins9_q;
  logic signed [CoordW-1:0] hx9_q, hy9_q;
  logic signed [VW-1:0] vx9_q, vy9_q;
  logic signed [WW-1:0] cmax, cmin;
  logic signed [CoordW-1:0] satx, saty;

  assign cmax = $signed(WW'({1'b0, {(CoordW-1){1'b1}}}));
  assign cmin = -cmax - WW'(1);
  assign satx = (wx8_q > cmax) ? cmax[CoordW-1:0] :
                (wx8_q < cmin) ? cmin[CoordW-1:0] : wx8_q[CoordW-1:0];
  assign saty = (wy8_q > cmax) ? cmax[CoordW-1:0] :
                (wy8_q < cmin) ? cmin[CoordW-1:0] : wy8_q[CoordW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      b9_q   <= b8_q;
      d9_q   <= d8_q;
      hit9_q <= hit8_q;
      ins9_q <= ins8_q;
      hx9_q  <= ins8_q ? b8_q.sx : satx;
      hy9_q  <= ins8_q ? b8_q.sy : saty;
      vx9_q  <= VW'(wx8_q) - VW'(b8_q.cx);
      vy9_q  <= VW'(wy8_q) - VW'(b8_q.cy);
    end
  end

  // s10: scale the vector into 32 bits, inside normal
  tail_t t10_q;
  logic [AW-1:0] ax10_q, ay10_q;
  logic signed [VW-1:0] vxs, vys;
  logic signed [DirW:0] ndx, ndy;
  logic signed [DirW-1:0] nsx, nsy;

  always_comb begin
    logic signed [VW-1:0] tx, ty, lim;
    lim = $signed(VW'({1'b0, {(CoordW-1){1'b1}}}));
    vxs = vx9_q >>> KMax;
    vys = vy9_q >>> KMax;
    for (int k = KMax; k >= 0; k--) begin
      tx = vx9_q >>> k;
      ty = vy9_q >>> k;
      if ((tx <= lim) && (tx >= -lim) && (ty <= lim) && (ty >= -lim)) begin
        vxs = tx;
        vys = ty;
      end
    end
  end

  assign ndx = -(DirW+1)'(b9_q.dx);
  assign ndy = -(DirW+1)'(b9_q.dy);
  assign nsx = (ndx[DirW] != ndx[DirW-1]) ? {1'b0, {(DirW-1){1'b1}}} : ndx[DirW-1:0];
  assign nsy = (ndy[DirW] != ndy[DirW-1]) ? {1'b0, {(DirW-1){1'b1}}} : ndy[DirW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      t10_q.hit <= hit9_q;
      t10_q.ins <= ins9_q;
      t10_q.hd  <= d9_q;
      t10_q.hx  <= hx9_q;
      t10_q.hy  <= hy9_q;
      t10_q.sgx <= vxs[VW-1];
      t10_q.sgy <= vys[VW-1];
      t10_q.nix <= nsx;
      t10_q.niy <= nsy;
      ax10_q    <= vxs[VW-1] ? AW'(-vxs) : vxs[AW-1:0];
      ay10_q    <= vys[VW-1] ? AW'(-vys) : vys[AW-1:0];
    end
  end

  // s11: squares of the normal vector
  tail_t t11_q;
  logic [AW-1:0] ax11_q, ay11_q;
  logic [2*AW-1:0] sqx11_q, sqy11_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t11_q   <= t10_q;
      ax11_q  <= ax10_q;
      ay11_q  <= ay10_q;
      sqx11_q <= ax10_q * ax10_q;
      sqy11_q <= ay10_q * ay10_q;
    end
  end

  // s12: squared length
  logic [2*LenW-1:0] rad12_q;
  pay2_t pay12_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad12_q    <= (2*LenW)'(sqx11_q) + (2*LenW)'(sqy11_q);
      pay12_q.t  <= t11_q;
      pay12_q.ax <= ax11_q;
      pay12_q.ay <= ay11_q;
    end
  end

  logic [LenW-1:0] len;
  logic [Pay2W-1:0] pay2_bits;
  pay2_t pay13;

  rdi_sqrt #(
    .RootW (LenW),
    .PayW  (Pay2W)
  ) u_sqrt_len (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  ('{adv: en, vld: v12_q}),
    .rad_i  (rad12_q),
    .pay_i  (pay12_q),
    .vld_o  (sq2_vld),
    .root_o (len),
    .pay_o  (pay2_bits)
  );

  assign pay13 = pay2_bits;

  // s13: rounded numerators for the normal
  logic [NumW-1:0] numx13_q, numy13_q;
  logic [LenW-1:0] len13_q;
  pay3_t pay13_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      numx13_q     <= NumW'({pay13.ax, DirFracW'(0)}) + NumW'(len[LenW-1:1]);
      numy13_q     <= NumW'({pay13.ay, DirFracW'(0)}) + NumW'(len[LenW-1:1]);
      len13_q      <= len;
      pay13_q.t    <= pay13.t;
      pay13_q.lenz <= (len == '0);
    end
  end

  logic [NormQuoW-1:0] qx, qy;
  logic [Pay3W-1:0] pay3_bits;
  pay3_t payf;

  rdi_div #(
    .QuoW (NormQuoW),
    .DenW (LenW),
    .PayW (Pay3W)
  ) u_div_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{adv: en, vld: v13_q}),
    .num_x_i (numx13_q),
    .num_y_i (numy13_q),
    .den_i   (len13_q),
    .pay_i   (pay13_q),
    .vld_o   (div_vld),
    .quo_x_o (qx),
    .quo_y_o (qy),
    .pay_o   (pay3_bits)
  );

  assign payf = pay3_bits;

  // output register
  logic                     hit_q;
  logic        [DistW-1:0]  hd_q;
  logic signed [CoordW-1:0] hx_q, hy_q;
  logic signed [DirW-1:0]   nx_q, ny_q;
  logic signed [DirW-1:0]   nux, nuy;

  assign nux = payf.t.sgx ? -DirW'(qx) : DirW'(qx);
  assign nuy = payf.t.sgy ? -DirW'(qy) : DirW'(qy);

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q <= payf.t.hit;
      hd_q  <= payf.t.hit ? payf.t.hd : '0;
      hx_q  <= payf.t.hit ? payf.t.hx : '0;
      hy_q  <= payf.t.hit ? payf.t.hy : '0;
      if (!payf.t.hit || (!payf.t.ins && payf.lenz)) begin
        nx_q <= '0;
        ny_q <= '0;
      end else if (payf.t.ins) begin
        nx_q <= payf.t.nix;
        ny_q <= payf.t.niy;
      end else begin
        nx_q <= nux;
        ny_q <= nuy;
      end
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.hit          = hit_q;
  assign out_o.hit_distance = hd_q;
  assign out_o.hit_x        = hx_q;
  assign out_o.hit_y        = hy_q;
  assign out_o.normal_x     = nx_q;
  assign out_o.normal_y     = ny_q;

  `RDI_ASSERT_IMP(a_miss_zero, out_v_q && !hit_q,
    (hd_q == '0) && (hx_q == '0) && (hy_q == '0) && (nx_q == '0) && (ny_q == '0))
  `RDI_ASSERT_IMP(a_norm_bound, out_v_q && hit_q && (hd_q != '0),
    (nx_q <= $signed(DirW'(1 << DirFracW))) && (nx_q >= -$signed(DirW'(1 << DirFracW))) &&
    (ny_q <= $signed(DirW'(1 << DirFracW))) && (ny_q >= -$signed(DirW'(1 << DirFracW))))
  `RDI_ASSERT_NXT(a_stall_hold, !en, $stable(v13_q) && $stable(v5_q) && $stable(out_v_q))

endmodule

// ===== dv/rdi_checker.sv =====
// checker for the ray/disc intersect: watches both channels, predicts each result
// depends on rdi_pkg and the rdi_in_if / rdi_out_if interfaces
`timescale 1ns / 1ps

module rdi_checker import rdi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rdi_in_if.sink      in_i,
  rdi_out_if.sink     out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned hits_o,
  output int unsigned misses_o
);

  typedef struct packed {
    logic                     hit;
    logic [DistW-1:0]         hdist;
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
    logic signed [DirW-1:0]   nx;
    logic signed [DirW-1:0]   ny;
  } hit_rec_t;

  hit_rec_t hits_q[$];

  function automatic longint floor_shr(longint x, int k);
    return x >>> k;
  endfunction

  function automatic longint round14(longint x);
    return (x + 64'sd8192) >>> 14;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint abs_l(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint unit_part(longint v, longint unsigned len);
    longint unsigned a, n;
    a = abs_l(v);
    n = (a * 16384 + len / 2) / len;
    return v < 0 ? -longint'(n) : longint'(n);
  endfunction

  function automatic hit_rec_t cast_ray(longint sx, longint sy, longint dx, longint dy,
                                        longint maxd, longint cx, longint cy, longint r);
    hit_rec_t res;
    longint ddx, ddy, p30, q30, r30, p16, q16, h2, d, wx, wy, vx, vy;
    longint unsigned len, ax, ay;
    res = '0;
    ddx = cx - sx;
    ddy = cy - sy;
    p30 = ddx * dx + ddy * dy;
    q30 = ddy * dx - ddx * dy;
    r30 = r * 16384;
    if (abs_l(q30) > r30) return '0;
    if (p30 <= -r30 || p30 >= (maxd + r) * 16384) return '0;
    if (abs_l(ddx) < r && abs_l(ddy) < r) begin
      ax = abs_l(ddx);
      ay = abs_l(ddy);
      if (ax * ax + ay * ay < longint'(r) * longint'(r)) begin
        res.hit = 1'b1;
        res.px = 32'(sx);
        res.py = 32'(sy);
        res.nx = 16'(clamp(-dx, -32768, 32767));
        res.ny = 16'(clamp(-dy, -32768, 32767));
        return res;
      end
    end
    p16 = round14(p30);
    q16 = round14(q30);
    h2 = r * r - q16 * q16;
    if (h2 <= 0) return '0;
    d = p16 - longint'(int_sqrt(h2));
    if (d >= maxd || d <= 0) return '0;
    res.hit = 1'b1;
    res.hdist = 31'(d);
    wx = sx + round14(d * dx);
    wy = sy + round14(d * dy);
    res.px = 32'(clamp(wx, -64'sd2147483648, 64'sd2147483647));
    res.py = 32'(clamp(wy, -64'sd2147483648, 64'sd2147483647));
    vx = wx - cx;
    vy = wy - cy;
    while (abs_l(vx) >= (64'sd1 << 31) || abs_l(vy) >= (64'sd1 << 31)) begin
      vx = floor_shr(vx, 1);
      vy = floor_shr(vy, 1);
    end
    len = int_sqrt(longint'(vx * vx) + longint'(vy * vy));
    if (len != 0) begin
      res.nx = 16'(unit_part(vx, len));
      res.ny = 16'(unit_part(vy, len));
    end
    return res;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  assign pending_o = hits_q.size();

  initial begin
    fail_count_o = 0;
    hits_o = 0;
    misses_o = 0;
  end

  always @(posedge clk_i) begin
    hit_rec_t exp_r;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready) begin
        hits_q.push_back(cast_ray(in_i.start_x, in_i.start_y, in_i.dir_x, in_i.dir_y,
                                  longint'({1'b0, in_i.max_distance}), in_i.center_x,
                                  in_i.center_y, longint'({1'b0, in_i.radius})));
      end
      if (out_i.valid && out_i.ready) begin
        if (hits_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          exp_r = hits_q.pop_front();
          if (exp_r.hit) hits_o++; else misses_o++;
          if (out_i.hit !== exp_r.hit) report("hit", out_i.hit, exp_r.hit);
          if (out_i.hit_distance !== exp_r.hdist)
            report("hit_distance", out_i.hit_distance, exp_r.hdist);
          if (out_i.hit_x !== exp_r.px) report("hit_x", out_i.hit_x, exp_r.px);
          if (out_i.hit_y !== exp_r.py) report("hit_y", out_i.hit_y, exp_r.py);
          if (out_i.normal_x !== exp_r.nx) report("normal_x", out_i.normal_x, exp_r.nx);
          if (out_i.normal_y !== exp_r.ny) report("normal_y", out_i.normal_y, exp_r.ny);
        end
      end
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for ray_disc_intersect_2d: directed and random rays against discs
// depends on rdi_pkg, rdi_if, the block and rdi_checker
`timescale 1ns / 1ps

module tb_top;
  import rdi_pkg::*;

  localparam int unsigned NumRandom = 1430;
  localparam int unsigned Latency   = 92;
  localparam longint      CycleCap  = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int unsigned fails, pending, hit_cnt, miss_cnt;
  longint cycles = 0;
  bit quiet = 1'b0;

  rdi_in_if  in_if ();
  rdi_out_if out_if ();

  ray_disc_intersect_2d dut (.clk_i, .rst_ni, .in_i(in_if.sink), .out_o(out_if.source));

  rdi_checker u_checker (
    .clk_i, .rst_ni, .in_i(in_if.sink), .out_i(out_if.sink),
    .fail_count_o(fails), .pending_o(pending), .hits_o(hit_cnt), .misses_o(miss_cnt)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side stall
  always @(negedge clk_i) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 11);
  end

  task automatic send_ray(logic [31:0] sx, logic [31:0] sy, logic [15:0] dx,
                          logic [15:0] dy, logic [30:0] maxd, logic [31:0] cx,
                          logic [31:0] cy, logic [30:0] r);
    while (!quiet && $urandom_range(99) < 11) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.start_x <= sx;
    in_if.start_y <= sy;
    in_if.dir_x <= dx;
    in_if.dir_y <= dy;
    in_if.max_distance <= maxd;
    in_if.center_x <= cx;
    in_if.center_y <= cy;
    in_if.radius <= r;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drop_valid();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // unit direction at a random angle, sometimes a raw random one
  task automatic pick_dir(output logic [15:0] dx, output logic [15:0] dy);
    real a;
    if ($urandom_range(9) == 0) begin
      dx = $urandom;
      dy = $urandom;
    end else begin
      a = $urandom_range(35999) * 3.14159265358979 / 18000.0;
      dx = 16'($rtoi($cos(a) * 16384.0));
      dy = 16'($rtoi($sin(a) * 16384.0));
    end
  endtask

  task automatic random_ray();
    logic [15:0] dx, dy;
    logic [31:0] sx, sy, cx, cy;
    logic [30:0] r, maxd;
    int sc, t;
    sc = $urandom_range(2);
    pick_dir(dx, dy);
    sx = (sc == 0) ? $urandom : $signed($urandom_range(2000000)) - 1000000;
    sy = (sc == 0) ? $urandom : $signed($urandom_range(2000000)) - 1000000;
    r = (sc == 0) ? $urandom : $urandom_range(800000);
    maxd = (sc == 0) ? $urandom : $urandom_range(20000000);
    t = $urandom_range(4000000);
    if (sc != 0) begin
      // aim the disc near the ray
      cx = sx + (($signed(dx) * t) >>> 14) + $signed($urandom_range(2 * r + 2)) - r;
      cy = sy + (($signed(dy) * t) >>> 14) + $signed($urandom_range(2 * r + 2)) - r;
    end else begin
      cx = $urandom;
      cy = $urandom;
    end
    send_ray(sx, sy, dx, dy, maxd, cx, cy, r);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.start_x = '0; in_if.start_y = '0;
    in_if.dir_x = '0; in_if.dir_y = '0;
    in_if.max_distance = '0;
    in_if.center_x = '0; in_if.center_y = '0;
    in_if.radius = '0;
    out_if.ready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: plain hit, inside start, miss, tangent, range edges, extremes
    send_ray(0, 0, 16384, 0, 100 << 16, 10 << 16, 0, 2 << 16);
    send_ray(0, 0, 16384, 0, 100 << 16, 1 << 16, 0, 2 << 16);
    send_ray(0, 0, 16384, 0, 100 << 16, 10 << 16, 5 << 16, 2 << 16);
    send_ray(0, 0, 16384, 0, 100 << 16, 10 << 16, 2 << 16, 2 << 16);
    send_ray(0, 0, 16384, 0, 8 << 16, 10 << 16, 0, 2 << 16);
    send_ray(0, 0, 16384, 0, 9 << 16, 10 << 16, 0, 2 << 16);
    send_ray(0, 0, 16384, 0, 100 << 16, -(10 << 16), 0, 2 << 16);
    send_ray(2 << 16, 0, 16384, 0, 100 << 16, 4 << 16, 0, 2 << 16);
    send_ray(0, 0, -16384, 0, 100 << 16, 0, 0, 1 << 16);
    send_ray(0, 0, 0, -16384, 100 << 16, 0, 0, 1 << 16);
    send_ray(0, 0, 16'h8000, 16'h8000, 31'h7fffffff, 0, 0, 31'h7fffffff);
    send_ray(0, 0, 16'h7fff, 16'h7fff, 31'h7fffffff, 32'h7fffffff, 32'h7fffffff, 5);
    send_ray(32'h80000000, 32'h80000000, 16384, 16384, 31'h7fffffff,
             32'h7fffffff, 32'h7fffffff, 31'h7fffffff);
    send_ray(32'h7fffffff, 32'h7fffffff, 16384, 0, 31'h7fffffff,
             32'h80000000, 32'h80000000, 31'h7fffffff);
    send_ray(32'h7fff0000, 0, 16384, 0, 31'h7fffffff, 32'h7fffffff, 0, 31'h40000000);
    send_ray(0, 0, 0, 0, 100 << 16, 10 << 16, 0, 2 << 16);
    send_ray(0, 0, 16384, 0, 0, 10 << 16, 0, 2 << 16);
    send_ray(0, 0, 16384, 0, 100 << 16, 10 << 16, 0, 0);
    send_ray(32'hffffffff, 32'hffffffff, 16'hffff, 16'hffff, 31'h7fffffff,
             32'hffffffff, 32'hffffffff, 31'h7fffffff);
    send_ray(0, 0, 11585, 11585, 1000 << 16, 20 << 16, 20 << 16, 3 << 16);
    drop_valid();

    // hold off until the pipe has drained
    while (pending != 0) @(negedge clk_i);

    for (int i = 0; i < NumRandom; i++) begin
      quiet = (i >= 500 && i < 700);
      random_ray();
    end
    quiet = 1'b0;
    drop_valid();

    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 20) @(negedge clk_i);

    $display("covered %0d hits and %0d misses over directed and random rays",
             hit_cnt, miss_cnt);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fails);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== ray_disc_intersect_2d.f =====
+incdir+hw/rtl
hw/rtl/rdi_pkg.sv
hw/rtl/rdi_if.sv
hw/rtl/rdi_sqrt.sv
hw/rtl/rdi_div.sv
hw/rtl/ray_disc_intersect_2d.sv
dv/rdi_checker.sv
dv/tb_top.sv
